>>> rtl/spq_pkg.sv
package spq_pkg;

   localparam int DATA_W = 32;

   localparam logic OP_PUT = 1'b0;
   localparam logic OP_GET = 1'b1;

   localparam logic [1:0] ST_DELIVERED = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   localparam logic [DATA_W-1:0] SIGN_FLIP = 32'h8000_0000;

   typedef struct packed {
      logic [DATA_W-1:0] prio;
      logic [DATA_W-1:0] arrival;
      logic [DATA_W-1:0] tag;
      logic [DATA_W-1:0] param;
   } data_type;

   typedef struct packed {
      logic     valid;
      data_type data;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic remove;
   } cmd_type;

   // true when a is served ahead of b; priority held with the sign bit flipped
   function automatic logic serve_before(input data_type a, input data_type b);
      logic res;
      if (a.prio != b.prio) begin
         res = a.prio < b.prio;
      end else begin
         res = a.arrival < b.arrival;
      end
      return res;
   endfunction

endpackage

>>> rtl/stable_min_priority_queue.sv
// A transferred request is held in the pending register; its response is computed from it
// and registered into rsp_valid. Puts that are stored give no response.
// A new request is not taken while busy is high; busy is high for the cycle in which the
// sorted cell row shifts. The receiver cannot stall the response.
// Reset: synchronous, clears every cell's valid bit, the entry count and the arrival
// counter; the queue is empty and idle on the first cycle after reset.
module stable_min_priority_queue #(
   parameter int CAPACITY = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_op,
   input  logic        [31:0] req_msg_tag,
   input  logic signed [31:0] req_param,
   input  logic signed [31:0] req_priority_req,
   output logic               rsp_valid,
   output logic        [1:0]  rsp_status,
   output logic        [31:0] rsp_out_tag,
   output logic signed [31:0] rsp_out_param
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic             pending_ff;
   logic             pending_in;
   logic             op_ff;
   logic             op_in;
   data_type         req_data_ff;
   data_type         req_data_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [31:0]      arrival_ff;
   logic [31:0]      arrival_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [1:0]       rsp_status_ff;
   logic [1:0]       rsp_status_in;
   logic [31:0]      rsp_tag_ff;
   logic [31:0]      rsp_tag_in;
   logic [31:0]      rsp_param_ff;
   logic [31:0]      rsp_param_in;

   logic      transfer;
   logic      full;
   logic      empty;
   cmd_type   cmd;
   entry_type new_entry;

   entry_type entry_w [CAPACITY];
   logic      gt_w    [CAPACITY];

   assign transfer = start && !pending_ff;
   assign busy     = pending_ff;
   assign full     = count_ff == CNT_W'(CAPACITY);
   assign empty    = count_ff == '0;

   assign cmd.insert = pending_ff && (op_ff == OP_PUT) && !full;
   assign cmd.remove = pending_ff && (op_ff == OP_GET) && !empty;

   always_comb begin
      new_entry              = '{valid: 1'b1, data: req_data_ff};
      new_entry.data.arrival = arrival_ff;
   end

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         entry_type left_entry;
         logic      left_gt;
         entry_type right_entry;

         if (i == 0) begin : g_head
            assign left_entry = '0;
            assign left_gt    = 1'b0;
         end else begin : g_mid
            assign left_entry = entry_w[i-1];
            assign left_gt    = gt_w[i-1];
         end

         if (i == CAPACITY - 1) begin : g_tail
            assign right_entry = '0;
         end else begin : g_body
            assign right_entry = entry_w[i+1];
         end

         spq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .cmd         (cmd),
            .new_entry   (new_entry),
            .left_entry  (left_entry),
            .left_gt     (left_gt),
            .right_entry (right_entry),
            .entry       (entry_w[i]),
            .gt          (gt_w[i])
         );
      end
   endgenerate

   always_comb begin
      pending_in  = pending_ff;
      op_in       = op_ff;
      req_data_in = req_data_ff;
      if (transfer) begin
         pending_in          = 1'b1;
         op_in               = req_op;
         req_data_in.prio    = req_priority_req ^ SIGN_FLIP;
         req_data_in.arrival = '0;
         req_data_in.tag     = req_msg_tag;
         req_data_in.param   = req_param;
      end else if (pending_ff) begin
         pending_in = 1'b0;
      end
   end

   always_comb begin
      count_in   = count_ff;
      arrival_in = arrival_ff;
      if (cmd.insert) begin
         count_in   = count_ff + CNT_W'(1);
         arrival_in = arrival_ff + 32'd1;
      end else if (cmd.remove) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in  = pending_ff && ((op_ff == OP_GET) || full);
      rsp_status_in = ST_FULL;
      rsp_tag_in    = '0;
      rsp_param_in  = '0;
      if (op_ff == OP_GET) begin
         if (empty) begin
            rsp_status_in = ST_EMPTY;
         end else begin
            rsp_status_in = ST_DELIVERED;
            rsp_tag_in    = entry_w[0].data.tag;
            rsp_param_in  = entry_w[0].data.param;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         count_ff     <= '0;
         arrival_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         count_ff     <= count_in;
         arrival_ff   <= arrival_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      req_data_ff   <= req_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_param_ff  <= rsp_param_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_tag   = rsp_tag_ff;
   assign rsp_out_param = rsp_param_ff;

endmodule

>>> rtl/spq_cell.sv
module spq_cell (
   input  logic               clock,
   input  logic               reset,
   input  spq_pkg::cmd_type   cmd,
   input  spq_pkg::entry_type new_entry,
   input  spq_pkg::entry_type left_entry,
   input  logic               left_gt,
   input  spq_pkg::entry_type right_entry,
   output spq_pkg::entry_type entry,
   output logic               gt
);
   import spq_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   data_type data_ff;
   data_type data_in;

   // new item sorts ahead of this cell (empty cells sort last)
   assign gt    = !valid_ff || serve_before(new_entry.data, data_ff);
   assign entry = '{valid: valid_ff, data: data_ff};

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (cmd.insert) begin
         if (gt) begin
            if (left_gt) begin
               valid_in = left_entry.valid;
               data_in  = left_entry.data;
            end else begin
               valid_in = 1'b1;
               data_in  = new_entry.data;
            end
         end
      end else if (cmd.remove) begin
         valid_in = right_entry.valid;
         data_in  = right_entry.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

>>> rtl/spq_checker.sv
module spq_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic        [1:0]  rsp_status,
   input logic        [31:0] rsp_out_tag,
   input logic signed [31:0] rsp_out_param
);
   import spq_pkg::*;

   a_busy_after_transfer: assert property (
      @(posedge clock) disable iff (reset) start && !busy |=> busy
   ) else $error("busy not raised after request transfer");

   a_busy_one_cycle: assert property (
      @(posedge clock) disable iff (reset) busy |=> !busy
   ) else $error("busy held for more than one cycle");

   a_rsp_follows_busy: assert property (
      @(posedge clock) disable iff (reset) rsp_valid |-> $past(busy) && !busy
   ) else $error("response without a request in progress");

   a_rsp_zero_payload: assert property (
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_status != ST_DELIVERED |-> rsp_out_tag == '0 && rsp_out_param == '0
   ) else $error("non-delivery response carries payload");

endmodule

bind stable_min_priority_queue spq_checker u_spq_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_status    (rsp_status),
   .rsp_out_tag   (rsp_out_tag),
   .rsp_out_param (rsp_out_param)
);
